// ----- hdl/dsaf_pkg.sv -----
// Shared types, constants and helpers for the drowsiness sensor alert fusion block.
package dsaf_pkg;

  localparam int unsigned PROX_HOLD_TICKS   = 500;
  localparam int unsigned BLINK_HOLD_TICKS  = 500;
  localparam int unsigned GRIP_REARM_TICKS  = 1000;
  localparam int unsigned FUSION_HOLD_TICKS = 1500;
  localparam int unsigned INTERVAL_WIDTH    = 16;

  localparam int unsigned ElapsedW = 11;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned IvCmpW   = (INTERVAL_WIDTH > 16) ? INTERVAL_WIDTH : 16;

  typedef logic [ElapsedW-1:0] elapsed_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROX_DELTA   = 3'd0,
    CFG_SHORT_BLINK  = 3'd1,
    CFG_FUSION_BLINK = 3'd2,
    CFG_PROX_LEVEL   = 3'd3,
    CFG_GRIP_WEAK    = 3'd4,
    CFG_GRIP_LOST    = 3'd5,
    CFG_SLOW_PULSE   = 3'd6,
    CFG_GRIP_TICKS   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GRIP_IDLE  = 2'd0,
    GRIP_LOW   = 2'd1,
    GRIP_ALERT = 2'd2,
    GRIP_REARM = 2'd3
  } grip_phase_e;

  typedef enum logic [2:0] {
    RULE_NONE        = 3'd0,
    RULE_BLINK_PROX  = 3'd1,
    RULE_BLINK_GRIP  = 3'd2,
    RULE_PROX_GRIP   = 3'd3,
    RULE_BLINK_PULSE = 3'd4,
    RULE_PROX_PULSE  = 3'd5,
    RULE_GRIP_PULSE  = 3'd6
  } fusion_rule_e;

  typedef struct packed {
    logic signed [8:0] prox_delta_threshold;
    logic [15:0]       short_blink_ticks;
    logic [15:0]       fusion_blink_ticks;
    logic [7:0]        proximity_threshold;
    logic [7:0]        grip_weak_threshold;
    logic [7:0]        grip_lost_threshold;
    logic [11:0]       slow_pulse_interval;
    logic [10:0]       grip_lost_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] proximity_change;
    logic [7:0]        proximity_level;
    logic [7:0]        grip_pressure;
    logic [11:0]       pulse_interval;
    logic              blink_seen;
    logic              buzzer_busy;
  } tick_in_t;

  typedef struct packed {
    logic        proximity_alert;
    logic        grip_alert;
    logic        blink_alert;
    logic        fusion_alert;
    logic [2:0]  fusion_rule;
    logic [1:0]  grip_phase;
    logic [15:0] blink_interval;
  } tick_out_t;

  typedef struct packed {
    logic        grip_alert;
    grip_phase_e phase;
  } grip_status_t;

  // Elapsed counters count up by one and stick at their all-ones value.
  function automatic elapsed_t tick_up(elapsed_t e);
    tick_up = (e == {ElapsedW{1'b1}}) ? e : e + elapsed_t'(1);
  endfunction

endpackage

// ----- hdl/drowsiness_sensor_alert_fusion_core.sv -----
// Top level of the drowsiness sensor alert fusion block.
// Latency: a result is valid in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle while each result is taken; the result register frees up as it is taken.
// Input ready is high whenever the result register is empty or being taken this cycle.
// Reset (rst_ni low, asynchronous) restores all registers but the result data to their defaults,
// clears every holdoff, counter and the grip machine, and empties the result register.
module drowsiness_sensor_alert_fusion_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsaf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dsaf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dsaf_pkg::tick_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dsaf_pkg::tick_out_t           out_data_o
);

  localparam int unsigned IvW = dsaf_pkg::INTERVAL_WIDTH;

  dsaf_pkg::cfg_t         cfg;
  dsaf_pkg::grip_status_t grip;
  logic                   accept;

  // All detector state advances only on an accepted transaction.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  dsaf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dsaf_grip_fsm u_grip (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (accept),
    .low_grip_i   (in_data_i.grip_pressure < cfg.grip_lost_threshold),
    .lost_ticks_i (cfg.grip_lost_ticks),
    .status_o     (grip)
  );

  // Approach alert: a large proximity jump fires once, then holds off.
  logic               prox_hold_q, prox_hold_d, prox_alert;
  dsaf_pkg::elapsed_t prox_elapsed_q, prox_elapsed_d;

  always_comb begin
    prox_hold_d    = prox_hold_q;
    prox_elapsed_d = dsaf_pkg::tick_up(prox_elapsed_q);
    prox_alert     = 1'b0;
    if ((in_data_i.proximity_change > cfg.prox_delta_threshold) && !prox_hold_q) begin
      prox_alert     = 1'b1;
      prox_hold_d    = 1'b1;
      prox_elapsed_d = '0;
    end else if (prox_elapsed_d >= dsaf_pkg::elapsed_t'(dsaf_pkg::PROX_HOLD_TICKS)) begin
      prox_hold_d = 1'b0;
    end
  end

  // Blink interval measurement. On a blink tick the running count becomes the
  // new interval and the count restarts at one; otherwise it saturates upward.
  logic [IvW-1:0]              since_blink_q, since_blink_d;
  logic [IvW-1:0]              last_iv_q, last_iv_d;
  logic [dsaf_pkg::IvCmpW-1:0] cur_iv_ext, last_iv_ext;
  logic                        blink_hold_q, blink_hold_d, blink_alert;
  dsaf_pkg::elapsed_t          blink_elapsed_q, blink_elapsed_d;

  assign cur_iv_ext = dsaf_pkg::IvCmpW'(since_blink_q);

  always_comb begin
    since_blink_d   = since_blink_q;
    last_iv_d       = last_iv_q;
    blink_hold_d    = blink_hold_q;
    blink_elapsed_d = dsaf_pkg::tick_up(blink_elapsed_q);
    blink_alert     = 1'b0;
    if (in_data_i.blink_seen) begin
      last_iv_d     = since_blink_q;
      since_blink_d = IvW'(1);
      if ((cur_iv_ext < dsaf_pkg::IvCmpW'(cfg.short_blink_ticks)) && !blink_hold_q) begin
        blink_alert     = 1'b1;
        blink_hold_d    = 1'b1;
        blink_elapsed_d = '0;
      end else if (blink_elapsed_d >=
                   dsaf_pkg::elapsed_t'(dsaf_pkg::BLINK_HOLD_TICKS)) begin
        blink_hold_d = 1'b0;
      end
    end else if (since_blink_q != {IvW{1'b1}}) begin
      since_blink_d = since_blink_q + IvW'(1);
    end
  end

  assign last_iv_ext = dsaf_pkg::IvCmpW'(last_iv_d);

  // Fusion: the first matching pair of conditions names the rule. The rule is
  // reported even while the holdoff blocks the alert. A busy buzzer skips the
  // evaluation entirely but the elapsed counter keeps running.
  logic                   bt, pt, gt, ht;
  logic                   fusion_hold_q, fusion_hold_d, fusion_alert;
  dsaf_pkg::elapsed_t     fusion_elapsed_q, fusion_elapsed_d;
  dsaf_pkg::fusion_rule_e rule;

  assign bt = in_data_i.blink_seen &&
              (cur_iv_ext < dsaf_pkg::IvCmpW'(cfg.fusion_blink_ticks));
  assign pt = in_data_i.proximity_level > cfg.proximity_threshold;
  assign gt = in_data_i.grip_pressure < cfg.grip_weak_threshold;
  assign ht = in_data_i.pulse_interval > cfg.slow_pulse_interval;

  always_comb begin
    fusion_hold_d    = fusion_hold_q;
    fusion_elapsed_d = dsaf_pkg::tick_up(fusion_elapsed_q);
    fusion_alert     = 1'b0;
    rule             = dsaf_pkg::RULE_NONE;
    if (!in_data_i.buzzer_busy) begin
      if (bt && pt)      rule = dsaf_pkg::RULE_BLINK_PROX;
      else if (bt && gt) rule = dsaf_pkg::RULE_BLINK_GRIP;
      else if (pt && gt) rule = dsaf_pkg::RULE_PROX_GRIP;
      else if (bt && ht) rule = dsaf_pkg::RULE_BLINK_PULSE;
      else if (pt && ht) rule = dsaf_pkg::RULE_PROX_PULSE;
      else if (gt && ht) rule = dsaf_pkg::RULE_GRIP_PULSE;
      if ((rule != dsaf_pkg::RULE_NONE) && !fusion_hold_q) begin
        fusion_alert     = 1'b1;
        fusion_hold_d    = 1'b1;
        fusion_elapsed_d = '0;
      end else if (fusion_elapsed_d >=
                   dsaf_pkg::elapsed_t'(dsaf_pkg::FUSION_HOLD_TICKS)) begin
        fusion_hold_d = 1'b0;
      end
    end
  end

  // Result assembly.
  dsaf_pkg::tick_out_t result;

  always_comb begin
    result.proximity_alert = prox_alert;
    result.grip_alert      = grip.grip_alert;
    result.blink_alert     = blink_alert;
    result.fusion_alert    = fusion_alert;
    result.fusion_rule     = rule;
    result.grip_phase      = grip.phase;
    result.blink_interval  = last_iv_ext[15:0];
  end

  // Detector state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prox_hold_q      <= 1'b0;
      prox_elapsed_q   <= '0;
      since_blink_q    <= '0;
      last_iv_q        <= '0;
      blink_hold_q     <= 1'b0;
      blink_elapsed_q  <= '0;
      fusion_hold_q    <= 1'b0;
      fusion_elapsed_q <= '0;
    end else if (accept) begin
      prox_hold_q      <= prox_hold_d;
      prox_elapsed_q   <= prox_elapsed_d;
      since_blink_q    <= since_blink_d;
      last_iv_q        <= last_iv_d;
      blink_hold_q     <= blink_hold_d;
      blink_elapsed_q  <= blink_elapsed_d;
      fusion_hold_q    <= fusion_hold_d;
      fusion_elapsed_q <= fusion_elapsed_d;
    end
  end

  // Result register: loads on every accepted transaction, empties when taken.
  logic                out_valid_q;
  dsaf_pkg::tick_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A fusion alert always carries the rule that caused it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fusion_alert |->
      out_data_o.fusion_rule != dsaf_pkg::RULE_NONE)
    else $error("fusion alert without a rule");

  // A shown approach alert means its holdoff is armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.proximity_alert |-> prox_hold_q)
    else $error("approach alert without holdoff");

  // A shown blink alert means its holdoff is armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.blink_alert |-> blink_hold_q)
    else $error("blink alert without holdoff");

  // The grip alert tick leaves the machine in the re-arm wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.grip_alert |->
      out_data_o.grip_phase == dsaf_pkg::GRIP_REARM)
    else $error("grip alert outside re-arm");

  // A tick with the buzzer busy leaves the fusion holdoff untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.buzzer_busy |=> $stable(fusion_hold_q))
    else $error("fusion holdoff changed while buzzer busy");

endmodule

// ----- hdl/dsaf_cfg_regs.sv -----
// Configuration register file with reset values and indexed writes.
module dsaf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dsaf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dsaf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output dsaf_pkg::cfg_t               cfg_o
);

  dsaf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dsaf_pkg::cfg_idx_e'(cfg_index_i))
        dsaf_pkg::CFG_PROX_DELTA:   cfg_d.prox_delta_threshold = $signed(cfg_wdata_i[8:0]);
        dsaf_pkg::CFG_SHORT_BLINK:  cfg_d.short_blink_ticks    = cfg_wdata_i[15:0];
        dsaf_pkg::CFG_FUSION_BLINK: cfg_d.fusion_blink_ticks   = cfg_wdata_i[15:0];
        dsaf_pkg::CFG_PROX_LEVEL:   cfg_d.proximity_threshold  = cfg_wdata_i[7:0];
        dsaf_pkg::CFG_GRIP_WEAK:    cfg_d.grip_weak_threshold  = cfg_wdata_i[7:0];
        dsaf_pkg::CFG_GRIP_LOST:    cfg_d.grip_lost_threshold  = cfg_wdata_i[7:0];
        dsaf_pkg::CFG_SLOW_PULSE:   cfg_d.slow_pulse_interval  = cfg_wdata_i[11:0];
        dsaf_pkg::CFG_GRIP_TICKS:   cfg_d.grip_lost_ticks      = cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prox_delta_threshold <= 9'sd130;
      cfg_q.short_blink_ticks    <= 16'd160;
      cfg_q.fusion_blink_ticks   <= 16'd500;
      cfg_q.proximity_threshold  <= 8'd180;
      cfg_q.grip_weak_threshold  <= 8'd85;
      cfg_q.grip_lost_threshold  <= 8'd60;
      cfg_q.slow_pulse_interval  <= 12'd1000;
      cfg_q.grip_lost_ticks      <= 11'd1500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/dsaf_grip_fsm.sv -----
// Grip-loss state machine: alerts after sustained low grip, then waits to re-arm.
module dsaf_grip_fsm (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     low_grip_i,
  input  dsaf_pkg::elapsed_t       lost_ticks_i,
  output dsaf_pkg::grip_status_t   status_o
);

  dsaf_pkg::grip_phase_e state_q, state_d;
  dsaf_pkg::elapsed_t    elapsed_q, elapsed_d, elapsed_up;

  assign elapsed_up = dsaf_pkg::tick_up(elapsed_q);

  // Next phase.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsaf_pkg::GRIP_IDLE: begin
        if (low_grip_i) state_d = dsaf_pkg::GRIP_LOW;
      end
      dsaf_pkg::GRIP_LOW: begin
        if (!low_grip_i) state_d = dsaf_pkg::GRIP_IDLE;
        else if (elapsed_up >= lost_ticks_i) state_d = dsaf_pkg::GRIP_ALERT;
      end
      dsaf_pkg::GRIP_ALERT: state_d = dsaf_pkg::GRIP_REARM;
      dsaf_pkg::GRIP_REARM: begin
        if (elapsed_up >= dsaf_pkg::elapsed_t'(dsaf_pkg::GRIP_REARM_TICKS)) begin
          state_d = dsaf_pkg::GRIP_IDLE;
        end
      end
      default: state_d = dsaf_pkg::GRIP_IDLE;
    endcase
  end

  // Alert and elapsed counter; the counter restarts on entry to low grip and on the alert.
  always_comb begin
    elapsed_d = elapsed_up;
    status_o.grip_alert = 1'b0;
    case (state_q)
      dsaf_pkg::GRIP_IDLE: begin
        if (low_grip_i) elapsed_d = '0;
      end
      dsaf_pkg::GRIP_ALERT: begin
        status_o.grip_alert = 1'b1;
        elapsed_d = '0;
      end
      default: ;
    endcase
    status_o.phase = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dsaf_pkg::GRIP_IDLE;
      elapsed_q <= '0;
    end else if (advance_i) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// ----- tb/dsaf_tb_pkg.sv -----
// Tick-by-tick alert predictor and result checker for the alert fusion testbench.
`timescale 1ns / 1ps

package dsaf_tb_pkg;
  import dsaf_pkg::*;

  class alert_fusion_model;
    // Register copies, reset values applied in new().
    logic signed [8:0] jump_lim;
    logic [15:0]       short_blink_lim;
    logic [15:0]       fuse_blink_lim;
    logic [7:0]        near_lim;
    logic [7:0]        weak_lim;
    logic [7:0]        lost_lim;
    logic [11:0]       slow_pulse_lim;
    logic [10:0]       lost_ticks_lim;

    bit                          prox_hold;
    bit                          blink_hold;
    bit                          fusion_hold;
    bit [10:0]                   prox_age;
    bit [10:0]                   grip_age;
    bit [10:0]                   blink_age;
    bit [10:0]                   fusion_age;
    grip_phase_e                 grip_state;
    bit [INTERVAL_WIDTH-1:0]     since_blink;
    bit [INTERVAL_WIDTH-1:0]     last_gap;

    tick_out_t alerts_due[$];
    int        mismatches;
    int        ticks;
    int        n_prox;
    int        n_grip;
    int        n_blink;
    int        n_fuse;
    bit [6:0]  rules_hit;

    function new();
      jump_lim        = 9'sd130;
      short_blink_lim = 16'd160;
      fuse_blink_lim  = 16'd500;
      near_lim        = 8'd180;
      weak_lim        = 8'd85;
      lost_lim        = 8'd60;
      slow_pulse_lim  = 12'd1000;
      lost_ticks_lim  = 11'd1500;
      grip_state      = GRIP_IDLE;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_PROX_DELTA:   jump_lim        = v[8:0];
        CFG_SHORT_BLINK:  short_blink_lim = v;
        CFG_FUSION_BLINK: fuse_blink_lim  = v;
        CFG_PROX_LEVEL:   near_lim        = v[7:0];
        CFG_GRIP_WEAK:    weak_lim        = v[7:0];
        CFG_GRIP_LOST:    lost_lim        = v[7:0];
        CFG_SLOW_PULSE:   slow_pulse_lim  = v[11:0];
        default:          lost_ticks_lim  = v[10:0];
      endcase
    endfunction

    // Elapsed counters stick at all ones.
    function bit [10:0] age(bit [10:0] e);
      return (&e) ? e : e + 11'd1;
    endfunction

    function int pending();
      return alerts_due.size();
    endfunction

    function void take_tick(tick_in_t t);
      tick_out_t    r;
      bit           low_grip;
      bit           bt;
      bit           pt;
      bit           gt;
      bit           ht;
      fusion_rule_e rule;
      r        = '0;
      rule     = RULE_NONE;
      low_grip = t.grip_pressure < lost_lim;

      prox_age = age(prox_age);
      if ($signed(t.proximity_change) > $signed(jump_lim) && !prox_hold) begin
        r.proximity_alert = 1'b1;
        prox_hold = 1'b1;
        prox_age  = '0;
      end else if (prox_age >= 11'(PROX_HOLD_TICKS)) begin
        prox_hold = 1'b0;
      end

      grip_age = age(grip_age);
      case (grip_state)
        GRIP_IDLE: begin
          if (low_grip) begin
            grip_state = GRIP_LOW;
            grip_age   = '0;
          end
        end
        GRIP_LOW: begin
          if (!low_grip) grip_state = GRIP_IDLE;
          else if (grip_age >= lost_ticks_lim) grip_state = GRIP_ALERT;
        end
        GRIP_ALERT: begin
          r.grip_alert = 1'b1;
          grip_age     = '0;
          grip_state   = GRIP_REARM;
        end
        default: begin
          if (grip_age >= 11'(GRIP_REARM_TICKS)) grip_state = GRIP_IDLE;
        end
      endcase

      blink_age = age(blink_age);
      if (t.blink_seen) begin
        last_gap    = since_blink;
        since_blink = INTERVAL_WIDTH'(1);
        if (last_gap < short_blink_lim && !blink_hold) begin
          r.blink_alert = 1'b1;
          blink_hold    = 1'b1;
          blink_age     = '0;
        end else if (blink_age >= 11'(BLINK_HOLD_TICKS)) begin
          blink_hold = 1'b0;
        end
      end else if (!(&since_blink)) begin
        since_blink = since_blink + INTERVAL_WIDTH'(1);
      end

      fusion_age = age(fusion_age);
      if (!t.buzzer_busy) begin
        bt = t.blink_seen && (last_gap < fuse_blink_lim);
        pt = t.proximity_level > near_lim;
        gt = t.grip_pressure < weak_lim;
        ht = t.pulse_interval > slow_pulse_lim;
        if (bt && pt)      rule = RULE_BLINK_PROX;
        else if (bt && gt) rule = RULE_BLINK_GRIP;
        else if (pt && gt) rule = RULE_PROX_GRIP;
        else if (bt && ht) rule = RULE_BLINK_PULSE;
        else if (pt && ht) rule = RULE_PROX_PULSE;
        else if (gt && ht) rule = RULE_GRIP_PULSE;
        if (rule != RULE_NONE && !fusion_hold) begin
          r.fusion_alert = 1'b1;
          fusion_hold    = 1'b1;
          fusion_age     = '0;
        end else if (fusion_age >= 11'(FUSION_HOLD_TICKS)) begin
          fusion_hold = 1'b0;
        end
      end

      r.fusion_rule    = rule;
      r.grip_phase     = grip_state;
      r.blink_interval = last_gap[15:0];
      alerts_due.push_back(r);

      ticks++;
      n_prox  += r.proximity_alert;
      n_grip  += r.grip_alert;
      n_blink += r.blink_alert;
      n_fuse  += r.fusion_alert;
      rules_hit[rule] = 1'b1;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void match_result(tick_out_t got);
      tick_out_t want;
      if (alerts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 20) $error("result %h arrived with no tick outstanding", got);
        return;
      end
      want = alerts_due.pop_front();
      check_field("proximity_alert", want.proximity_alert, got.proximity_alert);
      check_field("grip_alert", want.grip_alert, got.grip_alert);
      check_field("blink_alert", want.blink_alert, got.blink_alert);
      check_field("fusion_alert", want.fusion_alert, got.fusion_alert);
      check_field("fusion_rule", want.fusion_rule, got.fusion_rule);
      check_field("grip_phase", want.grip_phase, got.grip_phase);
      check_field("blink_interval", want.blink_interval, got.blink_interval);
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level testbench for the drowsiness sensor alert fusion core.
`timescale 1ns / 1ps

module tb_top;
  import dsaf_pkg::*;
  import dsaf_tb_pkg::*;

  // Generous bound: roughly 1100 ticks plus register writes.
  localparam int CycleLimit  = 40000;
  localparam int PhaseTicks  = 175;
  localparam int PhaseCount  = 6;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  tick_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  tick_out_t           out_data_o;

  alert_fusion_model model;

  // Random idling switches for each side, and the state of the stimulus shaper.
  bit tx_gaps   = 1'b1;
  bit rx_gaps   = 1'b1;
  int low_run   = 0;
  int busy_run  = 0;
  int blink_pct = 10;
  int settings  = 0;
  int cycles    = 0;

  drowsiness_sensor_alert_fusion_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // The result side stalls at random, changing only on falling edges.
  always @(negedge clk_i) begin
    out_ready_i <= !rx_gaps || ($urandom_range(0, 99) >= 14);
  end

  // Both handshakes are observed at the rising edge, where the block's outputs
  // still hold their values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) model.take_tick(in_data_i);
      if (out_valid_o && out_ready_i) model.match_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $error("run did not finish within %0d cycles", CycleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic cfg_t make_cfg(int pd, int sb, int fb, int pt, int gw, int gl, int sp,
                                    int gt);
    cfg_t c;
    c.prox_delta_threshold = 9'(pd);
    c.short_blink_ticks    = 16'(sb);
    c.fusion_blink_ticks   = 16'(fb);
    c.proximity_threshold  = 8'(pt);
    c.grip_weak_threshold  = 8'(gw);
    c.grip_lost_threshold  = 8'(gl);
    c.slow_pulse_interval  = 12'(sp);
    c.grip_lost_ticks      = 11'(gt);
    return c;
  endfunction

  // A mid-range setting drawn at random; the grip count is kept short so that
  // sustained low grip actually reaches the alert phase.
  function automatic cfg_t random_cfg(int max_grip_ticks);
    return make_cfg(int'($urandom_range(0, 200)) - 100, $urandom_range(2, 120),
                    $urandom_range(20, 600), $urandom_range(60, 230),
                    $urandom_range(40, 180), $urandom_range(30, 120),
                    $urandom_range(200, 3500), $urandom_range(0, max_grip_ticks));
  endfunction

  function automatic tick_in_t make_tick(int chg, int lvl, int prs, int pls, bit blk, bit bz);
    tick_in_t t;
    t.proximity_change = 9'(chg);
    t.proximity_level  = 8'(lvl);
    t.grip_pressure    = 8'(prs);
    t.pulse_interval   = 12'(pls);
    t.blink_seen       = blk;
    t.buzzer_busy      = bz;
    return t;
  endfunction

  // Random ticks are shaped as a driver would see them: mostly small proximity
  // changes with occasional jumps, runs of sustained low grip, and stretches of
  // buzzer activity. Level and pulse are drawn over their full range.
  function automatic tick_in_t random_tick();
    tick_in_t t;
    int       chg;
    if ($urandom_range(0, 7) == 0) chg = int'($urandom_range(0, 510)) - 255;
    else chg = int'($urandom_range(0, 60)) - 30;
    t.proximity_change = 9'(chg);
    t.proximity_level  = 8'($urandom);
    t.pulse_interval   = 12'($urandom);
    if (low_run > 0) begin
      low_run--;
      t.grip_pressure = 8'($urandom_range(0, 50));
    end else begin
      if ($urandom_range(0, 29) == 0) low_run = $urandom_range(2, 40);
      t.grip_pressure = 8'($urandom);
    end
    if (busy_run > 0) begin
      busy_run--;
      t.buzzer_busy = 1'b1;
    end else begin
      if ($urandom_range(0, 24) == 0) busy_run = $urandom_range(1, 15);
      t.buzzer_busy = 1'b0;
    end
    t.blink_seen = $urandom_range(0, 99) < blink_pct;
    return t;
  endfunction

  // Presents one tick and holds it until the transaction completes. Called and
  // returns at a falling edge.
  task automatic send_tick(tick_in_t t);
    if (tx_gaps && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stops sending, waits for every outstanding result, then idles before returning.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all eight registers back to back; only called while the block is idle.
  task automatic apply_config(cfg_t c);
    cfg_idx_e    idx;
    logic [15:0] v;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_PROX_DELTA:   v = {{7{c.prox_delta_threshold[8]}}, c.prox_delta_threshold};
        CFG_SHORT_BLINK:  v = c.short_blink_ticks;
        CFG_FUSION_BLINK: v = c.fusion_blink_ticks;
        CFG_PROX_LEVEL:   v = 16'(c.proximity_threshold);
        CFG_GRIP_WEAK:    v = 16'(c.grip_weak_threshold);
        CFG_GRIP_LOST:    v = 16'(c.grip_lost_threshold);
        CFG_SLOW_PULSE:   v = 16'(c.slow_pulse_interval);
        default:          v = 16'(c.grip_lost_ticks);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= v;
      model.set_reg(idx, v);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    cfg_t c;
    model = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed ticks at the reset register values.
    // All inputs at zero: the grip machine enters its low-grip phase.
    send_tick(make_tick(0, 0, 0, 0, 1'b0, 1'b0));
    // Largest jump, all levels at their top, and a blink with a running count of
    // one: approach, blink and the blink-plus-near fusion rule fire
    // together, and grip recovery sends the grip machine back to idle.
    send_tick(make_tick(255, 255, 255, 4095, 1'b1, 1'b0));
    // A change of -255 with the buzzer sounding: fusion is skipped.
    send_tick(make_tick(-255, 0, 0, 0, 1'b1, 1'b1));
    // A jump just above threshold inside the approach holdoff, while the fusion
    // holdoff still reports the near-plus-weak rule without alerting.
    send_tick(make_tick(131, 200, 10, 0, 1'b0, 1'b0));
    // A change equal to the threshold must not count as a jump.
    send_tick(make_tick(130, 0, 10, 0, 1'b1, 1'b0));
    // Walk the remaining rules: blink plus pulse, near plus pulse, grip plus pulse.
    send_tick(make_tick(0, 0, 200, 2000, 1'b1, 1'b0));
    send_tick(make_tick(0, 200, 200, 2000, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 10, 2000, 1'b0, 1'b0));
    // Every fusion term present but the buzzer busy: the rule reads as none.
    send_tick(make_tick(0, 200, 10, 4095, 1'b1, 1'b1));
    settle();

    // A two-tick grip count lets sustained low grip run the grip machine
    // through the alert phase into its re-arm wait.
    apply_config(make_cfg(100, 160, 500, 180, 85, 60, 1000, 2));
    repeat (5) send_tick(make_tick(0, 0, 0, 0, 1'b0, 1'b0));
    send_tick(make_tick(0, 0, 255, 0, 1'b0, 1'b0));
    settle();

    // Random phases, each under its own register setting. The grip machine's
    // re-arm wait spans most of the run, so the last phase uses a short grip
    // count to catch a second alert once it has re-armed.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       c = make_cfg(130, 160, 500, 180, 85, 60, 1000, 1500);
        1:       c = make_cfg(-255, 0, 0, 0, 0, 0, 0, 0);
        2:       c = make_cfg(255, 65535, 65535, 255, 255, 255, 4095, 2047);
        3:       c = random_cfg(30);
        4:       c = random_cfg(30);
        default: c = random_cfg(8);
      endcase
      apply_config(c);
      blink_pct = $urandom_range(3, 25);
      // Phase three runs with neither side idling.
      tx_gaps   = (p != 3);
      rx_gaps   = (p != 3);
      repeat (PhaseTicks) send_tick(random_tick());
      settle();
    end

    $display("Covered %0d ticks under %0d register settings; alerts: approach %0d,",
             model.ticks, settings, model.n_prox);
    $display("  grip %0d, blink %0d, fusion %0d; fusion rules reported: %0d of 6.",
             model.n_grip, model.n_blink, model.n_fuse, $countones(model.rules_hit[6:1]));
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
